// ----- hw/rtl/fpt_pkg.sv -----
`timescale 1ns / 1ps

package fpt_pkg;

  localparam int X_W = 32;
  localparam int Y_W = 18;

  // coefficients of the continued-fraction approximation and the clamp point
  localparam int C3   = 3;
  localparam int C10  = 10;
  localparam int C45  = 45;
  localparam int C105 = 105;

  typedef enum logic [1:0] {
    SEL_CORE,
    SEL_NEG_ONE,
    SEL_POS_ONE
  } sel_t;

endpackage

// ----- hw/rtl/fixed_point_tanh_unit.sv -----
`timescale 1ns / 1ps
// tanh of a signed fixed-point sample, x(10x^2+105)/(x^4+45x^2+105), clamped beyond +/-3.0
// stage order: range check, x^2, products, numerator and denominator, divider load, division, output register
// throughput: one request per cycle while the output is not stalled; the divider resolves one quotient bit per stage
// stalls back up stage by stage, empty stages fill while the output waits
// reset (synchronous, active high) clears all stage valid bits; data registers are not reset

module fixed_point_tanh_unit
  import fpt_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [X_W-1:0] x,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [Y_W-1:0] y
);

  localparam int F   = FRAC_BITS;
  localparam int XS  = F + 3;          // signed x inside +/-3.0
  localparam int UW  = F + 2;          // |x| inside 3.0
  localparam int SQW = 2 * UW;
  localparam int SW  = F + 4;          // s <= 9.0
  localparam int PW  = XS + SW + 1;    // x * s
  localparam int TW  = PW + 4;         // 10 * x * s
  localparam int SSW = 2 * SW;
  localparam int AW  = F + 11;         // numerator, signed
  localparam int BW  = F + 10;         // denominator and numerator magnitude
  localparam int QW  = F + 2;          // quotient bits
  localparam int YF  = (QW + 1 > Y_W) ? QW + 1 : Y_W;
  localparam int NS  = QW + 6;         // number of register stages

  localparam logic signed [X_W-1:0] LIM      = X_W'(C3) <<< F;
  localparam logic signed [AW-1:0]  K105A    = AW'(C105);
  localparam logic [BW-1:0]         K45B     = BW'(C45);
  localparam logic [BW-1:0]         K105B    = BW'(C105) << F;
  localparam logic signed [YF-1:0]  ONE_Y    = YF'(1) <<< F;

  logic [NS:1] v;
  logic [NS:1] en;
  logic [NS:1] vp;

  always_comb begin
    en[NS] = !v[NS] || out_ready;
    for (int k = NS - 1; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign vp        = {v[NS-1:1], in_valid};
  assign in_ready  = en[1];
  assign out_valid = v[NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (en[k]) begin
          v[k] <= vp[k];
        end
      end
    end
  end

  // stage 1: range check and magnitude
  logic signed [XS-1:0] x1;
  logic [UW-1:0]        u1;
  sel_t                 sel1;
  logic signed [X_W-1:0] xa;

  assign xa = x[X_W-1] ? -x : x;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      x1 <= $signed(x[XS-1:0]);
      u1 <= xa[UW-1:0];
      if (x < -LIM) begin
        sel1 <= SEL_NEG_ONE;
      end else if (x > LIM) begin
        sel1 <= SEL_POS_ONE;
      end else begin
        sel1 <= SEL_CORE;
      end
    end
  end

  // stage 2: x^2
  logic [SQW-1:0]       sq2;
  logic signed [XS-1:0] x2;
  sel_t                 sel2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sq2  <= u1 * u1;
      x2   <= x1;
      sel2 <= sel1;
    end
  end

  // stage 3: s = floor(x^2), then x*s and s*s
  logic [SW-1:0]        s2;
  logic [SW-1:0]        s3;
  logic signed [PW-1:0] ps3;
  logic [SSW-1:0]       ss3;
  logic signed [XS-1:0] x3;
  sel_t                 sel3;

  assign s2 = sq2[SQW-1:F];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3   <= s2;
      ps3  <= x2 * $signed({1'b0, s2});
      ss3  <= s2 * s2;
      x3   <= x2;
      sel3 <= sel2;
    end
  end

  // stage 4: numerator and denominator
  logic signed [TW-1:0] p10;
  logic signed [TW-1:0] p10_sh;
  logic signed [AW-1:0] a_next;
  logic [BW-1:0]        b_next;
  logic signed [AW-1:0] a4;
  logic [BW-1:0]        b4;
  sel_t                 sel4;

  assign p10    = TW'(ps3) * TW'(C10);
  assign p10_sh = p10 >>> F;
  assign a_next = $signed(p10_sh[AW-1:0]) + AW'(x3) * K105A;
  assign b_next = BW'(ss3[SSW-1:F]) + BW'(s3) * K45B + K105B;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      a4   <= a_next;
      b4   <= b_next;
      sel4 <= sel3;
    end
  end

  // stage 5 loads the divider, later stages do restoring division of |a| << F by b, one bit per stage
  logic [BW-1:0] dr [0:QW];
  logic [QW-1:0] dq [0:QW];
  logic [BW-1:0] db [0:QW];
  logic          dn [0:QW];
  sel_t          ds [0:QW];

  logic signed [AW-1:0] ua_full;

  assign ua_full = a4[AW-1] ? -a4 : a4;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      dr[0] <= BW'(ua_full[BW-1:2]);
      dq[0] <= {ua_full[1:0], {F{1'b0}}};
      db[0] <= b4;
      dn[0] <= a4[AW-1];
      ds[0] <= sel4;
    end
  end

  for (genvar i = 1; i <= QW; i++) begin : g_div
    logic [BW:0]   rs;
    logic [BW:0]   rd;
    logic          ge;

    assign rs = {dr[i-1], dq[i-1][QW-1]};
    assign ge = rs >= {1'b0, db[i-1]};
    assign rd = rs - {1'b0, db[i-1]};

    always_ff @(posedge clk) begin
      if (en[5+i]) begin
        dr[i] <= ge ? rd[BW-1:0] : rs[BW-1:0];
        dq[i] <= {dq[i-1][QW-2:0], ge};
        db[i] <= db[i-1];
        dn[i] <= dn[i-1];
        ds[i] <= ds[i-1];
      end
    end
  end

  // last stage: sign, clamp, truncate to the output field
  logic signed [QW:0]   qs;
  logic signed [YF-1:0] yf;

  assign qs = dn[QW] ? -$signed({1'b0, dq[QW]}) : $signed({1'b0, dq[QW]});

  always_comb begin
    case (ds[QW])
      SEL_NEG_ONE: yf = -ONE_Y;
      SEL_POS_ONE: yf = ONE_Y;
      default:     yf = YF'(qs);
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[NS]) begin
      y <= $signed(yf[Y_W-1:0]);
    end
  end

endmodule

// ----- hw/rtl/fpt_checker.sv -----
`timescale 1ns / 1ps

module fpt_checker
  import fpt_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic signed [Y_W-1:0] y
);

  localparam int ONE = 2 ** FRAC_BITS;

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(y))
    else $error("result changed or dropped while stalled");

  // with the output free every stage can move, so the input must be open
  a_in_open: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled while the output side is free");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result presented right after reset");

  // tanh stays within minus one to plus one when the field can hold it
  a_y_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (FRAC_BITS > 16) || (y >= -ONE && y <= ONE))
    else $error("result outside minus one to plus one");

  // after an accepted request, in_ready must not be unknown
  a_accept_known: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$isunknown(in_ready))
    else $error("input ready unknown after an accepted request");

endmodule

bind fixed_point_tanh_unit fpt_checker #(
  .FRAC_BITS(FRAC_BITS)
) u_fpt_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .y        (y)
);
